[hw/rtl/controller_command_framer_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the command framer
// Implication checks clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CONTROLLER_COMMAND_FRAMER_TOP_ASSERT_SVH
`define CONTROLLER_COMMAND_FRAMER_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define CCF_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication.
`define CCF_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define CCF_ASSERT_NOW(label, pre, post)
`define CCF_ASSERT_NEXT(label, pre, post)
`endif
`endif

[hw/rtl/ccf_pkg.sv]
// ----------------------------------------------------------------------------
// ccf_pkg
// Shared types, constants and the CRC byte step of the command framer.
// ----------------------------------------------------------------------------
`default_nettype none
package ccf_pkg;

   localparam logic [1:0] OP_WRITE16 = 2'd0;
   localparam logic [1:0] OP_WRITE8  = 2'd1;
   localparam logic [1:0] OP_SAVE    = 2'd2;
   localparam logic [1:0] OP_UNUSED  = 2'd3;

   localparam logic [7:0]  FRAME_SOF   = 8'hAA;
   localparam logic [7:0]  HDR_WRITE16 = 8'hC6;
   localparam logic [7:0]  HDR_WRITE8  = 8'hC5;
   localparam logic [15:0] CRC_INIT    = 16'h7F3C;
   localparam logic [15:0] CRC_POLY    = 16'hA001;

   // Frame positions
   localparam logic [2:0] POS_FIRST = 3'd0;
   localparam logic [2:0] POS_1     = 3'd1;
   localparam logic [2:0] POS_2     = 3'd2;
   localparam logic [2:0] POS_3     = 3'd3;
   localparam logic [2:0] POS_4     = 3'd4;
   localparam logic [2:0] POS_5     = 3'd5;
   localparam logic [2:0] POS_6     = 3'd6;
   localparam logic [2:0] POS_7     = 3'd7;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  target_code;
      logic [7:0]  sub_code;
      logic [15:0] data_word;
   } ccf_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } ccf_qstat_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                            input logic [7:0]  data);
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/controller_command_framer_top.sv]
// A request beat carries one command and produces a frame of seven or eight
// response beats, one byte per beat, the final one flagged by rsp_last_byte:
// a 16-bit write sends AA C6 addr addr lo hi crcL crcH, an 8-bit write sends
// AA C5 addr addr val crcL crcH (Modbus-style CRC, reflected 0xA001, seeded
// 7F3C, low byte first), and a save sends AA cmd ~cmd sub v1 v2 sum ~sum.
// Opcode 3 is accepted and dropped without any response. The response side
// emits one byte per cycle while rsp_stall is low, so that serializer sets
// the sustained rate; a two-entry command queue lets the request side take
// new commands while a frame is still being sent, and the first byte of a
// frame is registered at the output only after its command is queued.
// ----------------------------------------------------------------------------
// controller_command_framer_top
// Command framer: request decode, command queue and byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none
module controller_command_framer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [7:0]  req_target_code,
   input  wire logic [7:0]  req_sub_code,
   input  wire logic [15:0] req_data_word,
   // Response channel, one frame byte per beat
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_frame_byte,
   output logic             rsp_last_byte
);
   import ccf_pkg::*;

   logic           push, pop;
   ccf_cmd_type    push_cmd, head_cmd;
   ccf_qstat_type  qstat;

   // Front: accept beats, drop the unused opcode.
   ccf_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_target_code (req_target_code),
      .req_sub_code    (req_sub_code),
      .req_data_word   (req_data_word),
      .qstat           (qstat),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   // Queue: hold commands until the serializer gets to them.
   ccf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .qstat    (qstat)
   );

   // Back: advance one frame byte per free output slot, pop on the last byte.
   ccf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_cmd       (head_cmd),
      .qstat          (qstat),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

`include "controller_command_framer_top_assert.svh"

   // Queue status is never both full and empty.
   `CCF_ASSERT_NOW(a_qstat_sane, 1'b1, !(qstat.full && qstat.empty))
   // A framed command lands in the queue.
   `CCF_ASSERT_NEXT(a_push_lands, push && !pop, !qstat.empty)
   // After a last byte goes out, any following byte opens a new frame.
   `CCF_ASSERT_NEXT(a_frame_start, rsp_valid && !rsp_stall && rsp_last_byte,
      !rsp_valid || (rsp_frame_byte == FRAME_SOF))
   // Dropped opcode never reaches the queue.
   `CCF_ASSERT_NOW(a_drop_unused, req_opcode == OP_UNUSED, !push)

endmodule
`default_nettype wire

[hw/rtl/ccf_front.sv]
// ----------------------------------------------------------------------------
// ccf_front
// Accepts request beats, drops the unused opcode, packs commands for the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module ccf_front (
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_opcode,
   input  wire logic [7:0]           req_target_code,
   input  wire logic [7:0]           req_sub_code,
   input  wire logic [15:0]          req_data_word,
   input  wire ccf_pkg::ccf_qstat_type qstat,
   output logic                      push,
   output ccf_pkg::ccf_cmd_type      push_cmd
);
   import ccf_pkg::*;

   logic accept;

   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;

   // Unused opcode frames nothing: accept and drop it.
   assign push = accept && (req_opcode != OP_UNUSED);

   always_comb begin
      push_cmd.opcode      = req_opcode;
      push_cmd.target_code = req_target_code;
      push_cmd.sub_code    = req_sub_code;
      push_cmd.data_word   = req_data_word;
   end

endmodule
`default_nettype wire

[hw/rtl/ccf_queue.sv]
// ----------------------------------------------------------------------------
// ccf_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module ccf_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire ccf_pkg::ccf_cmd_type  push_cmd,
   input  wire logic                  pop,
   output ccf_pkg::ccf_cmd_type       head_cmd,
   output ccf_pkg::ccf_qstat_type     qstat
);
   import ccf_pkg::*;

   ccf_cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   logic                    do_push, do_pop;

   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head_cmd    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/ccf_back.sv]
// ----------------------------------------------------------------------------
// ccf_back
// Walks the head command byte by byte, folding CRC and checksum as it goes.
// ----------------------------------------------------------------------------
`default_nettype none
module ccf_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ccf_pkg::ccf_cmd_type   head_cmd,
   input  wire ccf_pkg::ccf_qstat_type qstat,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_frame_byte,
   output logic                        rsp_last_byte
);
   import ccf_pkg::*;

   logic        rsp_valid_ff;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [2:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in, crc_cur;
   logic [7:0]  sum_ff, sum_in, sum_cur;
   logic        out_free, load, crc_body;
   logic [7:0]  lo, hi;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = !qstat.empty && out_free;
   assign pop      = load && last_in;

   assign lo      = head_cmd.data_word[7:0];
   assign hi      = head_cmd.data_word[15:8];
   assign crc_cur = (pos_ff == POS_FIRST) ? CRC_INIT : crc_ff;
   assign sum_cur = (pos_ff == POS_FIRST) ? 8'h00 : sum_ff;

   always_comb begin
      byte_in = FRAME_SOF;
      if (head_cmd.opcode == OP_SAVE) begin
         unique case (pos_ff)
            POS_FIRST: byte_in = FRAME_SOF;
            POS_1:     byte_in = head_cmd.target_code;
            POS_2:     byte_in = ~head_cmd.target_code;
            POS_3:     byte_in = head_cmd.sub_code;
            POS_4:     byte_in = lo;
            POS_5:     byte_in = hi;
            POS_6:     byte_in = sum_cur;
            POS_7:     byte_in = ~sum_cur;
            default:   byte_in = FRAME_SOF;
         endcase
      end else if (head_cmd.opcode == OP_WRITE8) begin
         unique case (pos_ff)
            POS_FIRST: byte_in = FRAME_SOF;
            POS_1:     byte_in = HDR_WRITE8;
            POS_2:     byte_in = head_cmd.target_code;
            POS_3:     byte_in = head_cmd.target_code;
            POS_4:     byte_in = lo;
            POS_5:     byte_in = crc_cur[7:0];
            default:   byte_in = crc_cur[15:8];
         endcase
      end else begin
         unique case (pos_ff)
            POS_FIRST: byte_in = FRAME_SOF;
            POS_1:     byte_in = HDR_WRITE16;
            POS_2:     byte_in = head_cmd.target_code;
            POS_3:     byte_in = head_cmd.target_code;
            POS_4:     byte_in = lo;
            POS_5:     byte_in = hi;
            POS_6:     byte_in = crc_cur[7:0];
            default:   byte_in = crc_cur[15:8];
         endcase
      end
   end

   always_comb begin
      last_in  = (head_cmd.opcode == OP_WRITE8) ? (pos_ff == POS_6) : (pos_ff == POS_7);
      crc_body = (head_cmd.opcode == OP_WRITE8) ? (pos_ff < POS_5) : (pos_ff < POS_6);
      pos_in   = last_in ? POS_FIRST : pos_ff + 1'b1;
      crc_in   = crc_body ? crc_byte(crc_cur, byte_in) : crc_cur;
      sum_in   = (pos_ff < POS_6) ? sum_cur + byte_in : sum_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff       <= POS_FIRST;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= !qstat.empty;
         end
         if (load) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         crc_ff  <= crc_in;
         sum_ff  <= sum_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_last_byte  = last_ff;

endmodule
`default_nettype wire

[dv/tb_controller_command_framer_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_controller_command_framer_top
// Self-checking bench for the command framer. Each command beat is sent
// through a bursty valid/stall driver. A local predictor builds the expected
// frame bytes: a Modbus-style CRC for writes and an additive checksum for
// saves. Every response beat is compared against the oldest expected byte.
// Phases: directed corner commands, a random mix, and a long receiver
// hold-off that backs the block up into its request side.
// ----------------------------------------------------------------------------
module tb_controller_command_framer_top;
   import ccf_pkg::*;

   // One expected response beat
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } frame_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [7:0]  req_target_code = '0;
   logic [7:0]  req_sub_code = '0;
   logic [15:0] req_data_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last_byte;

   // Predictor state, mirrors the block's own registers
   logic [15:0] crc_state = CRC_INIT;
   logic [7:0]  sum_state = '0;

   frame_beat_type frame_beats_due[$];
   frame_beat_type head_beat;
   int unsigned error_count = 0;

   // Sender burst control
   bit          sender_bursty = 1'b1;
   int unsigned burst_left = 0;

   // Receiver stall pattern and the long hold-off used to fill the block
   bit          hold_off_pending = 1'b0;
   int unsigned hold_off_left = 0;
   int unsigned rsp_cycle = 0;

   controller_command_framer_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_target_code (req_target_code),
      .req_sub_code    (req_sub_code),
      .req_data_word   (req_data_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

   always #5 clock = ~clock;

   // Reflected CRC-16 step over one byte, LSB first
   function automatic logic [15:0] crc_step(input logic [15:0] seed,
                                            input logic [7:0]  data);
      logic [15:0] acc;
      acc = seed ^ {8'h00, data};
      repeat (8) acc = {1'b0, acc[15:1]} ^ (acc[0] ? CRC_POLY : 16'h0000);
      return acc;
   endfunction

   // Build the frame a command produces and queue its bytes in order.
   // Unused opcodes produce nothing.
   function automatic void predict_frame(input ccf_cmd_type cmd);
      logic [7:0]  frame [8];
      int unsigned body;
      int unsigned length;
      frame_beat_type beat;
      length = 0;
      case (cmd.opcode) inside
         OP_SAVE: begin
            frame[0] = FRAME_SOF;
            frame[1] = cmd.target_code;
            frame[2] = ~cmd.target_code;
            frame[3] = cmd.sub_code;
            frame[4] = cmd.data_word[7:0];
            frame[5] = cmd.data_word[15:8];
            sum_state = '0;
            for (int i = 0; i < 6; i++) sum_state = sum_state + frame[i];
            frame[6] = sum_state;
            frame[7] = ~sum_state;
            length = 8;
         end
         OP_WRITE16, OP_WRITE8: begin
            frame[0] = FRAME_SOF;
            frame[1] = (cmd.opcode == OP_WRITE16) ? HDR_WRITE16 : HDR_WRITE8;
            frame[2] = cmd.target_code;
            frame[3] = cmd.target_code;
            frame[4] = cmd.data_word[7:0];
            frame[5] = cmd.data_word[15:8];
            body = (cmd.opcode == OP_WRITE16) ? 6 : 5;
            crc_state = CRC_INIT;
            for (int i = 0; i < body; i++) crc_state = crc_step(crc_state, frame[i]);
            frame[body]     = crc_state[7:0];
            frame[body + 1] = crc_state[15:8];
            length = body + 2;
         end
         default: length = 0;
      endcase
      for (int i = 0; i < length; i++) begin
         beat.frame_byte = frame[i];
         beat.last_byte  = (i == length - 1);
         frame_beats_due.push_back(beat);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t: mismatch on %s: got %02h, want %02h", $time, what, got, want);
      error_count++;
   endtask

   // Offer one command beat and hold it until accepted. Called at a rising
   // edge. After acceptance, drop valid for a random gap at the end of a
   // burst; otherwise leave it high so the next beat follows back to back.
   task automatic send_command(input logic [1:0] op, input logic [7:0] tgt,
                               input logic [7:0] sub, input logic [15:0] dw);
      ccf_cmd_type cmd;
      int unsigned gap;
      cmd = '{opcode: op, target_code: tgt, sub_code: sub, data_word: dw};
      req_opcode      <= op;
      req_target_code <= tgt;
      req_sub_code    <= sub;
      req_data_word   <= dw;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_frame(cmd);
      if (sender_bursty) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 16);
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Receiver: a long hold-off when asked, otherwise a stall pattern that
   // rotates with bits 7:6 of the cycle count between free-running, light
   // random stalls, a fixed one-in-three stall and heavy random stalls.
   always @(posedge clock) begin
      rsp_cycle++;
      if (hold_off_pending) begin
         hold_off_left = 200;
         hold_off_pending = 1'b0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (rsp_cycle[7:6])
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2'd2: rsp_stall <= (rsp_cycle % 3 == 0);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   // Response checker: compare each accepted byte with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_beats_due.size() == 0) begin
            report_mismatch("unexpected frame byte", rsp_frame_byte, 8'h00);
         end else begin
            head_beat = frame_beats_due.pop_front();
            if (rsp_frame_byte !== head_beat.frame_byte)
               report_mismatch("frame_byte", rsp_frame_byte, head_beat.frame_byte);
            if (rsp_last_byte !== head_beat.last_byte)
               report_mismatch("last_byte", {7'd0, rsp_last_byte},
                               {7'd0, head_beat.last_byte});
         end
      end
   end

   // Corner commands: field extremes, every opcode, ignored fields, and the
   // unused opcode that must produce no bytes.
   task automatic test_directed_frames();
      send_command(OP_WRITE16, 8'h00, 8'h00, 16'h0000);
      send_command(OP_WRITE16, 8'hFF, 8'hFF, 16'hFFFF);
      send_command(OP_WRITE16, 8'h5A, 8'hA5, 16'h1234);   // sub ignored
      send_command(OP_WRITE8,  8'h00, 8'h00, 16'h0000);
      send_command(OP_WRITE8,  8'hFF, 8'hFF, 16'hFFFF);   // high byte ignored
      send_command(OP_WRITE8,  8'h3C, 8'h00, 16'hAB00);
      send_command(OP_SAVE,    8'h00, 8'h00, 16'h0000);
      send_command(OP_SAVE,    8'hFF, 8'hFF, 16'hFFFF);   // checksum wraps
      send_command(OP_SAVE,    8'h80, 8'h7F, 16'h8001);
      send_command(OP_UNUSED,  8'hFF, 8'hFF, 16'hFFFF);
      send_command(OP_UNUSED,  8'h00, 8'h00, 16'h0000);
      send_command(OP_WRITE16, 8'hC6, 8'h00, 16'hFF00);
      send_command(OP_UNUSED,  8'h12, 8'h34, 16'h5678);
      send_command(OP_SAVE,    8'h01, 8'hFE, 16'h55AA);
      send_command(OP_WRITE8,  8'hC3, 8'h3C, 16'h00FF);
      send_command(OP_WRITE16, 8'h7F, 8'h80, 16'h00FF);
   endtask

   // Random mix, mostly valid opcodes; fields sometimes pinned to extremes
   task automatic test_random_commands(input int unsigned frames);
      int unsigned framed;
      logic [1:0]  op;
      logic [7:0]  tgt;
      logic [15:0] dw;
      framed = 0;
      while (framed < frames) begin
         op = ($urandom_range(0, 9) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
         case ($urandom_range(0, 7))
            0:       tgt = 8'h00;
            1:       tgt = 8'hFF;
            default: tgt = 8'($urandom);
         endcase
         dw = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
         send_command(op, tgt, 8'($urandom), dw);
         if (op != OP_UNUSED) framed++;
      end
   endtask

   // Hold the receiver off for a long stretch while commands keep coming
   // back to back, so the queue fills and the request side stalls.
   task automatic test_receiver_hold_off();
      sender_bursty = 1'b0;
      hold_off_pending = 1'b1;
      for (int i = 0; i < 12; i++)
         send_command(2'($urandom_range(0, 2)), 8'($urandom), 8'($urandom),
                      16'($urandom));
      sender_bursty = 1'b1;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_random_commands(110);
      test_receiver_hold_off();
      test_random_commands(8);
      // Idle the request side, then drain outstanding bytes and let the
      // pipeline settle before judging the run.
      req_valid <= 1'b0;
      while (frame_beats_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_controller_command_framer_top: clean");
      end else begin
         $display("tb_controller_command_framer_top: errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("tb_controller_command_framer_top: errors");
      $finish;
   end

endmodule
